@@ hw/rtl/pcrn_pkg.sv @@
// shared types, request codes and contract constants for the contract negotiator
package pcrn_pkg;

   // request codes
   localparam logic [7:0] REQ_END       = 8'h00;
   localparam logic [7:0] REQ_REPING    = 8'h05;
   localparam logic [7:0] REQ_CHARGE    = 8'h07;
   localparam logic [7:0] REQ_FREQ      = 8'hF0;
   localparam logic [7:0] REQ_POWER     = 8'hF3;
   localparam logic [7:0] REQ_CPING_LO  = 8'hF5;
   localparam logic [7:0] REQ_PROFILE   = 8'hF6;
   localparam logic [7:0] REQ_CPING_HI  = 8'hF7;
   localparam logic [7:0] REQ_CDET      = 8'hF8;

   // configuration register indexes
   localparam logic [1:0] CSR_QI_VERSION = 2'd0;
   localparam logic [1:0] CSR_CHARGE_MIN = 2'd1;
   localparam logic [1:0] CSR_CHARGE_MAX = 2'd2;

   // limits
   localparam logic [7:0] QI_VERSION_MIN   = 8'h21;
   localparam logic [7:0] POWER_MAX        = 8'd150;
   localparam logic [5:0] REPING_MASK_BITS = 6'h3F;

   // configuration reset values
   localparam logic [7:0] QI_VERSION_RST = 8'h21;
   localparam logic [7:0] CHARGE_MIN_RST = 8'd0;
   localparam logic [7:0] CHARGE_MAX_RST = 8'd255;

   typedef enum logic [1:0] {
      RSP_ACK = 2'd0,
      RSP_NAK = 2'd1,
      RSP_ND  = 2'd2
   } rsp_code_type;

   typedef struct packed {
      logic [9:0] cping;
      logic [7:0] cdet;
      logic       profile;
      logic [7:0] power;
      logic       freq;
      logic [7:0] charge;
      logic [7:0] reping;
   } contract_type;

   localparam contract_type CONTRACT_RST = '{
      cping:   10'd5,
      cdet:    8'd0,
      profile: 1'b0,
      power:   8'd50,
      freq:    1'b0,
      charge:  8'd5,
      reping:  8'd5
   };

   typedef struct packed {
      rsp_code_type response;
      logic         ended;
      contract_type committed;
   } result_type;

endpackage

@@ hw/rtl/pcrn_in_reg.sv @@
// input register stage holding one accepted request item
module pcrn_in_reg import pcrn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_code,
   input  logic [7:0] in_param,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_code,
   output logic [7:0] held_param
);

   logic       valid_ff, valid_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] param_ff, param_in;
   logic       take;

   // free when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      param_in = param_ff;
      if (take) begin
         valid_in = 1'b1;
         code_in  = in_code;
         param_in = in_param;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff  <= code_in;
      param_ff <= param_in;
   end

   assign held_valid = valid_ff;
   assign held_code  = code_ff;
   assign held_param = param_ff;

endmodule

@@ hw/rtl/pcrn_core.sv @@
// contract registers, configuration registers and request evaluation
module pcrn_core import pcrn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata,
   input  logic       step,
   input  logic [7:0] code,
   input  logic [7:0] param,
   output result_type result
);

   logic [7:0]   qi_version_ff, qi_version_in;
   logic [7:0]   charge_min_ff, charge_min_in;
   logic [7:0]   charge_max_ff, charge_max_in;
   contract_type committed_ff, committed_in;
   contract_type pending_ff, pending_in;
   contract_type pending_nxt;
   contract_type committed_nxt;
   rsp_code_type response;
   logic         ended;
   logic [2:0]   field_diffs;
   logic [5:0]   reping_bits;

   // configuration writes
   always_comb begin
      qi_version_in = qi_version_ff;
      charge_min_in = charge_min_ff;
      charge_max_in = charge_max_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_QI_VERSION: qi_version_in = csr_wdata;
            CSR_CHARGE_MIN: charge_min_in = csr_wdata;
            CSR_CHARGE_MAX: charge_max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // number of pending fields differing from the committed contract
   always_comb begin
      field_diffs = 3'd0;
      field_diffs = field_diffs + {2'd0, committed_ff.reping  != pending_ff.reping};
      field_diffs = field_diffs + {2'd0, committed_ff.charge  != pending_ff.charge};
      field_diffs = field_diffs + {2'd0, committed_ff.freq    != pending_ff.freq};
      field_diffs = field_diffs + {2'd0, committed_ff.power   != pending_ff.power};
      field_diffs = field_diffs + {2'd0, committed_ff.profile != pending_ff.profile};
      field_diffs = field_diffs + {2'd0, committed_ff.cdet    != pending_ff.cdet};
      field_diffs = field_diffs + {2'd0, committed_ff.cping   != pending_ff.cping};
   end

   assign reping_bits = param[5:0] & REPING_MASK_BITS;

   // request decode and contract update
   always_comb begin
      pending_nxt   = pending_ff;
      committed_nxt = committed_ff;
      response      = RSP_ND;
      ended         = 1'b0;
      case (code)
         REQ_END: begin
            if (param == {5'd0, field_diffs}) begin
               committed_nxt = pending_ff;
               response      = RSP_ACK;
               ended         = 1'b1;
            end else begin
               pending_nxt = committed_ff;
               response    = RSP_NAK;
            end
         end
         REQ_REPING: begin
            // times 200 over 100 is a doubling
            if (reping_bits != 6'd0) begin
               pending_nxt.reping = {1'b0, reping_bits, 1'b0};
               response           = RSP_ACK;
            end else begin
               response = RSP_NAK;
            end
         end
         REQ_CHARGE: begin
            if (qi_version_ff >= QI_VERSION_MIN) begin
               if (param < charge_min_ff || param > charge_max_ff) begin
                  response = RSP_NAK;
               end else begin
                  pending_nxt.charge = param;
                  response           = RSP_ACK;
               end
            end
         end
         REQ_FREQ: begin
            if (param[1:0] == 2'b01) begin
               pending_nxt.freq = 1'b1;
               response         = RSP_ACK;
            end
         end
         REQ_POWER: begin
            if (param > POWER_MAX) begin
               response = RSP_NAK;
            end else begin
               pending_nxt.power = param;
               response          = RSP_ACK;
            end
         end
         REQ_CPING_LO: begin
            pending_nxt.cping = {pending_ff.cping[9:8], param};
            response          = RSP_ACK;
         end
         REQ_PROFILE: begin
            pending_nxt.profile = param[0];
            response            = RSP_ACK;
         end
         REQ_CPING_HI: begin
            pending_nxt.cping = {param[1:0], pending_ff.cping[7:0]};
            response          = RSP_ACK;
         end
         REQ_CDET: begin
            pending_nxt.cdet = param;
            response         = RSP_ACK;
         end
         default: response = RSP_ND;
      endcase
   end

   assign pending_in   = step ? pending_nxt : pending_ff;
   assign committed_in = step ? committed_nxt : committed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qi_version_ff <= QI_VERSION_RST;
         charge_min_ff <= CHARGE_MIN_RST;
         charge_max_ff <= CHARGE_MAX_RST;
         committed_ff  <= CONTRACT_RST;
         pending_ff    <= CONTRACT_RST;
      end else begin
         qi_version_ff <= qi_version_in;
         charge_min_ff <= charge_min_in;
         charge_max_ff <= charge_max_in;
         committed_ff  <= committed_in;
         pending_ff    <= pending_in;
      end
   end

   assign result.response  = response;
   assign result.ended     = ended;
   assign result.committed = committed_nxt;

endmodule

@@ hw/rtl/power_contract_request_negotiator_top.sv @@
// top level of the wireless-power contract request negotiator
//
// Takes one specific request item per cycle on the req_ stream (code and
// parameter) while req_tready is high, and gives exactly one response item
// per request on the rsp_ stream. Each response carries the answer code, the
// committed contract after the request, and on rsp_tlast the flag that an
// end request was accepted and the pending contract committed.
// An item passes an input register and a result register: rsp_tvalid rises
// once the held item moves into the result register, which it does while
// that register is free or draining; a new item may enter every cycle
// while rsp_tready stays high.
// When rsp_tready is low the result register holds its item; one more
// request waits in the input register, then req_tready drops.
// The csr_ port writes receiver version and charge delay bounds; the user
// must write only while no item is in flight, the block does not enforce it.
// Reset (synchronous, active high) empties both stages, sets both
// contracts to their defaults and the configuration to its reset values.
module power_contract_request_negotiator_top import pcrn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // request_code [7:0], request_param [15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // response [1:0], reping_delay [9:2],
                                    // charge_delay [17:10], frequency_select [18],
                                    // negotiated_power [26:19], control_profile [27],
                                    // cloak_detect_delay [35:28],
                                    // cloak_ping_delay [45:36], zero [47:46]
   output logic        rsp_tlast,   // negotiation_ended
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   logic       held_valid;
   logic [7:0] held_code;
   logic [7:0] held_param;
   logic       advance;
   result_type result;
   result_type result_ff, result_in;
   logic       out_valid_ff, out_valid_in;

   // a held item moves when the result register is free or draining
   assign advance = held_valid && (!out_valid_ff || rsp_tready);

   pcrn_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_code    (req_tdata[7:0]),
      .in_param   (req_tdata[15:8]),
      .advance    (advance),
      .held_valid (held_valid),
      .held_code  (held_code),
      .held_param (held_param)
   );

   pcrn_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .code      (held_code),
      .param     (held_param),
      .result    (result)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = result_ff.ended;
   assign rsp_tdata  = {2'b00,
                        result_ff.committed.cping,
                        result_ff.committed.cdet,
                        result_ff.committed.profile,
                        result_ff.committed.power,
                        result_ff.committed.freq,
                        result_ff.committed.charge,
                        result_ff.committed.reping,
                        result_ff.response};

endmodule

@@ tb/power_contract_request_negotiator_top_tb.sv @@
// self-checking testbench for the contract request negotiator, streamed requests vs predictor
`timescale 1ns / 1ps

module power_contract_request_negotiator_top_tb import pcrn_pkg::*; ();

   // index past the register list, writes there must change nothing
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int PHASE_ITEMS = 72;
   localparam int HOLD_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // request_code [7:0], request_param [15:8]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // response [1:0], reping [9:2], charge [17:10], freq [18],
                             // power [26:19], profile [27], cdet [35:28], cping [45:36]
   logic        rsp_tlast;   // negotiation_ended
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [7:0]  csr_wdata;

   // predictor state
   contract_type committed_model;
   contract_type pending_model;
   logic [7:0]   version_model;
   logic [7:0]   charge_min_model;
   logic [7:0]   charge_max_model;

   result_type answer_q[$];
   int         mismatch_count;
   bit         quiet;
   bit         hold_rsp;

   // directed rows: response and end flag typed in only where obvious
   typedef struct packed {
      logic [7:0]   code;
      logic [7:0]   param;
      logic         typed;
      rsp_code_type rsp;
      logic         ended;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 25;
   directed_row_type directed_table [0:DIRECTED_ROWS-1] = '{
      '{REQ_END,      8'h00, 1'b1, RSP_ACK, 1'b1},
      '{REQ_END,      8'h01, 1'b1, RSP_NAK, 1'b0},
      '{REQ_REPING,   8'h00, 1'b1, RSP_NAK, 1'b0},
      '{REQ_REPING,   8'hC0, 1'b1, RSP_NAK, 1'b0},
      '{REQ_REPING,   8'h3F, 1'b0, RSP_ACK, 1'b0},
      '{REQ_REPING,   8'hFF, 1'b0, RSP_ACK, 1'b0},
      '{REQ_CHARGE,   8'h00, 1'b0, RSP_ACK, 1'b0},
      '{REQ_CHARGE,   8'hFF, 1'b0, RSP_ACK, 1'b0},
      '{REQ_FREQ,     8'h00, 1'b1, RSP_ND,  1'b0},
      '{REQ_FREQ,     8'h01, 1'b0, RSP_ACK, 1'b0},
      '{REQ_FREQ,     8'hFD, 1'b0, RSP_ACK, 1'b0},
      '{REQ_POWER,    8'd150, 1'b0, RSP_ACK, 1'b0},
      '{REQ_POWER,    8'd151, 1'b1, RSP_NAK, 1'b0},
      '{REQ_POWER,    8'hFF, 1'b1, RSP_NAK, 1'b0},
      '{REQ_CPING_LO, 8'hFF, 1'b0, RSP_ACK, 1'b0},
      '{REQ_CPING_HI, 8'hFF, 1'b0, RSP_ACK, 1'b0},
      '{REQ_PROFILE,  8'hFF, 1'b0, RSP_ACK, 1'b0},
      '{REQ_CDET,     8'hFF, 1'b0, RSP_ACK, 1'b0},
      '{8'h01,        8'h55, 1'b1, RSP_ND,  1'b0},
      '{8'hFF,        8'hAA, 1'b1, RSP_ND,  1'b0},
      '{REQ_END,      8'hFF, 1'b1, RSP_NAK, 1'b0},
      '{REQ_POWER,    8'h00, 1'b0, RSP_ACK, 1'b0},
      '{REQ_PROFILE,  8'h01, 1'b0, RSP_ACK, 1'b0},
      '{REQ_END,      8'h02, 1'b0, RSP_ACK, 1'b0},
      '{REQ_END,      8'h00, 1'b0, RSP_ACK, 1'b0}
   };

   power_contract_request_negotiator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   // number of pending fields that differ from the committed contract
   function automatic int count_changed_fields();
      int n;
      n = 0;
      n += int'(pending_model.reping  != committed_model.reping);
      n += int'(pending_model.charge  != committed_model.charge);
      n += int'(pending_model.freq    != committed_model.freq);
      n += int'(pending_model.power   != committed_model.power);
      n += int'(pending_model.profile != committed_model.profile);
      n += int'(pending_model.cdet    != committed_model.cdet);
      n += int'(pending_model.cping   != committed_model.cping);
      return n;
   endfunction

   // answer to one request, updating the contract copies
   function automatic result_type negotiate_request(input logic [7:0] code,
                                                    input logic [7:0] param);
      result_type  res;
      logic [15:0] reping_calc;
      res.response = RSP_ND;
      res.ended    = 1'b0;
      case (code)
         REQ_END: begin
            if (int'(param) == count_changed_fields()) begin
               committed_model = pending_model;
               res.response    = RSP_ACK;
               res.ended       = 1'b1;
            end else begin
               pending_model = committed_model;
               res.response  = RSP_NAK;
            end
         end
         REQ_REPING: begin
            reping_calc = 16'(param & 8'(REPING_MASK_BITS)) * 16'd200 / 16'd100;
            if (reping_calc != 16'd0) begin
               pending_model.reping = reping_calc[7:0];
               res.response = RSP_ACK;
            end else begin
               res.response = RSP_NAK;
            end
         end
         REQ_CHARGE: begin
            if (version_model < QI_VERSION_MIN) begin
               res.response = RSP_ND;
            end else if (param < charge_min_model || param > charge_max_model) begin
               res.response = RSP_NAK;
            end else begin
               pending_model.charge = param;
               res.response = RSP_ACK;
            end
         end
         REQ_FREQ: begin
            if (param[1:0] == 2'b01) begin
               pending_model.freq = 1'b1;
               res.response = RSP_ACK;
            end
         end
         REQ_POWER: begin
            if (param > POWER_MAX) begin
               res.response = RSP_NAK;
            end else begin
               pending_model.power = param;
               res.response = RSP_ACK;
            end
         end
         REQ_CPING_LO: begin
            pending_model.cping = {pending_model.cping[9:8], param};
            res.response = RSP_ACK;
         end
         REQ_PROFILE: begin
            pending_model.profile = param[0];
            res.response = RSP_ACK;
         end
         REQ_CPING_HI: begin
            pending_model.cping = {param[1:0], pending_model.cping[7:0]};
            res.response = RSP_ACK;
         end
         REQ_CDET: begin
            pending_model.cdet = param;
            res.response = RSP_ACK;
         end
         default: res.response = RSP_ND;
      endcase
      res.committed = committed_model;
      return res;
   endfunction

   function automatic logic [7:0] code_by_index(input int idx);
      case (idx)
         0: return REQ_END;
         1: return REQ_REPING;
         2: return REQ_CHARGE;
         3: return REQ_FREQ;
         4: return REQ_POWER;
         5: return REQ_CPING_LO;
         6: return REQ_PROFILE;
         7: return REQ_CPING_HI;
         default: return REQ_CDET;
      endcase
   endfunction

   // parameters lean toward the edges of each validation rule
   function automatic logic [7:0] pick_param(input logic [7:0] code);
      int pick;
      pick = $urandom_range(0, 5);
      if (code == REQ_CHARGE) begin
         case (pick)
            0: return charge_min_model;
            1: return charge_max_model;
            2: return charge_min_model - 8'd1;
            3: return charge_max_model + 8'd1;
            default: return 8'($urandom);
         endcase
      end
      if (code == REQ_POWER && pick < 2) return (pick == 0) ? POWER_MAX : POWER_MAX + 8'd1;
      case (pick)
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(input string what, input logic [47:0] got,
                                input logic [47:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // offer one item and hold it until taken, valid stays high on return
   task automatic send_request(input logic [7:0] code, input logic [7:0] param,
                               input logic typed, input rsp_code_type rsp,
                               input logic ended);
      result_type want;
      req_tvalid <= 1'b1;
      req_tdata  <= {param, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = negotiate_request(code, param);
      if (typed) begin
         want.response = rsp;
         want.ended    = ended;
      end
      answer_q.push_back(want);
   endtask

   // random sender gap
   task automatic sender_pause();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   // program all registers, optionally a stray write past the list
   task automatic write_settings(input logic [7:0] version, input logic [7:0] cmin,
                                 input logic [7:0] cmax, input bit stray);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_QI_VERSION;
      csr_wdata <= version;
      @(posedge clock);
      csr_addr  <= CSR_CHARGE_MIN;
      csr_wdata <= cmin;
      @(posedge clock);
      csr_addr  <= CSR_CHARGE_MAX;
      csr_wdata <= cmax;
      @(posedge clock);
      if (stray) begin
         csr_addr  <= CSR_SPARE;
         csr_wdata <= 8'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      version_model    = version;
      charge_min_model = cmin;
      charge_max_model = cmax;
   endtask

   // mostly well-formed negotiations ending in an end request, some noise
   task automatic run_negotiations(input int item_goal);
      int         sent;
      logic [7:0] code;
      logic [7:0] param;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(0, 9) == 0) begin
            code  = 8'($urandom);
            param = 8'($urandom);
            sender_pause();
            send_request(code, param, 1'b0, RSP_ACK, 1'b0);
            sent++;
         end else begin
            repeat ($urandom_range(1, 5)) begin
               code  = code_by_index($urandom_range(1, 8));
               param = pick_param(code);
               sender_pause();
               send_request(code, param, 1'b0, RSP_ACK, 1'b0);
               sent++;
            end
            // end request with the right change count most of the time
            if ($urandom_range(0, 4) == 0) param = 8'($urandom_range(0, 8));
            else param = 8'(count_changed_fields());
            sender_pause();
            send_request(REQ_END, param, 1'b0, RSP_ACK, 1'b0);
            sent++;
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata, 48'd0);
         end else begin
            want = answer_q.pop_front();
            compare_field("response", 48'(rsp_tdata[1:0]), 48'(want.response));
            compare_field("negotiation_ended", 48'(rsp_tlast), 48'(want.ended));
            compare_field("reping_delay", 48'(rsp_tdata[9:2]),
                          48'(want.committed.reping));
            compare_field("charge_delay", 48'(rsp_tdata[17:10]),
                          48'(want.committed.charge));
            compare_field("frequency_select", 48'(rsp_tdata[18]),
                          48'(want.committed.freq));
            compare_field("negotiated_power", 48'(rsp_tdata[26:19]),
                          48'(want.committed.power));
            compare_field("control_profile", 48'(rsp_tdata[27]),
                          48'(want.committed.profile));
            compare_field("cloak_detect_delay", 48'(rsp_tdata[35:28]),
                          48'(want.committed.cdet));
            compare_field("cloak_ping_delay", 48'(rsp_tdata[45:36]),
                          48'(want.committed.cping));
            compare_field("padding", 48'(rsp_tdata[47:46]), 48'd0);
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
            hold_rsp = 1'b0;
         end else if (!reset && !quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // main sequence
   initial begin
      mismatch_count   = 0;
      quiet            = 1'b0;
      hold_rsp         = 1'b0;
      committed_model  = CONTRACT_RST;
      pending_model    = CONTRACT_RST;
      version_model    = QI_VERSION_RST;
      charge_min_model = CHARGE_MIN_RST;
      charge_max_model = CHARGE_MAX_RST;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_QI_VERSION;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed requests at reset settings
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_table[i].code, directed_table[i].param,
                      directed_table[i].typed, directed_table[i].rsp,
                      directed_table[i].ended);
      end
      req_tvalid <= 1'b0;
      wait_drained();

      // version below threshold, stray register write, long receiver hold-off
      write_settings(8'h20, 8'd0, 8'd255, 1'b1);
      hold_rsp = 1'b1;
      run_negotiations(PHASE_ITEMS);
      wait_drained();

      write_settings(8'hFF, 8'd10, 8'd200, 1'b0);
      run_negotiations(PHASE_ITEMS);
      wait_drained();

      write_settings(8'h00, 8'd0, 8'd255, 1'b1);
      run_negotiations(PHASE_ITEMS);
      wait_drained();

      // inverted charge delay bounds
      write_settings(QI_VERSION_MIN, 8'd200, 8'd10, 1'b0);
      run_negotiations(PHASE_ITEMS);
      wait_drained();

      write_settings(QI_VERSION_MIN, 8'd0, 8'd0, 1'b0);
      run_negotiations(PHASE_ITEMS);
      wait_drained();

      write_settings(8'hFF, 8'd255, 8'd255, 1'b0);
      run_negotiations(PHASE_ITEMS);
      wait_drained();

      // closing stretch with no idling on either side
      quiet = 1'b1;
      write_settings(8'($urandom), 8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)),
                     1'b1);
      run_negotiations(PHASE_ITEMS);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/pcrn_pkg.sv
hw/rtl/pcrn_in_reg.sv
hw/rtl/pcrn_core.sv
hw/rtl/power_contract_request_negotiator_top.sv
tb/power_contract_request_negotiator_top_tb.sv
